// File: rtl/acbc_pkg.sv
package acbc_pkg;

    // field widths
    localparam int unsigned NOW_W    = 32;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned ADJ_W    = 7;
    localparam int unsigned FREQ_W   = 11;
    localparam int unsigned TMS_W    = 9;

    // stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 48;

    // configuration register indexes
    typedef enum logic {
        CFG_LONG_PRESS   = 1'b0,
        CFG_EDIT_TIMEOUT = 1'b1
    } t_cfg_index;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] EDIT_TIMEOUT_RST = 16'd5000;

    localparam logic [HOUR_W-1:0]   ALARM_HOUR_RST = 5'd12;
    localparam logic [HOUR_W-1:0]   HOUR_MAX       = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX     = 6'd59;

    // tones
    localparam logic [FREQ_W-1:0] BEEP_FREQ  = 11'd500;
    localparam logic [TMS_W-1:0]  BEEP_MS    = 9'd100;
    localparam logic [FREQ_W-1:0] RESET_FREQ = 11'd800;
    localparam logic [TMS_W-1:0]  RESET_MS   = 9'd200;
    localparam logic [FREQ_W-1:0] RING_BASE  = 11'd1000;
    localparam logic [TMS_W-1:0]  RING_MS    = 9'd500;

    localparam logic [ADJ_W-1:0] ADJ_HOUR   = 7'sd60;
    localparam logic [ADJ_W-1:0] ADJ_MINUTE = 7'sd1;

    // now / 200 = (now >> 3) / 25, quotient by reciprocal multiply
    localparam logic [31:0] DIV25_MAGIC = 32'h51EB851F;
    localparam int unsigned DIV25_SHIFT = 35;

    typedef struct packed {
        logic                btn_mode;
        logic                btn_min_down;
        logic                btn_min_up;
        logic                btn_hour_down;
        logic                btn_hour_up;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [NOW_W-1:0]    now_ms;
    } t_sample;

    typedef struct packed {
        logic                tone_stop;
        logic [TMS_W-1:0]    tone_ms;
        logic [FREQ_W-1:0]   tone_freq;
        logic                reset_request;
        logic [ADJ_W-1:0]    adjust_minutes;
        logic                ringing;
        logic [MINUTE_W-1:0] alarm_minute_out;
        logic [HOUR_W-1:0]   alarm_hour_out;
        logic                edit_mode;
    } t_result;

endpackage

// File: rtl/alarm_clock_button_controller.sv
// alarm clock button controller
//
// s side: one sample per transaction (timestamp, clock time, five button levels).
// m side: one result per sample (edit flag, alarm time, ringing, clock adjustment,
//   reset request and tone request).
// cfg side: i_cfg_we writes i_cfg_wdata to register i_cfg_index at the clock edge;
//   write only while no sample is in flight; the block does not enforce this.
//
// path: a sample accepted on the s side lands in the input register; its result
//   then reaches the m side through the result register.
// throughput: one sample per cycle unless the m side stalls; all state updates are
//   one level of compares and small adds between the input and result registers.
//   The ringing tone frequency needs now_ms mod 200, taken by a reciprocal multiply
//   before the input register so it does not sit in the state loop.
// stall: while o_m_tvalid is high and i_m_tready low the result holds; the input
//   register still takes one more sample, then o_s_tready drops.
// reset: synchronous, active low; both registers empty, alarm 12:00, edit mode
//   off, no ringing, long press 1000 ms, edit timeout 5000 ms.
module alarm_clock_button_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // now_ms[31:0], hour[36:32], minute[42:37], second[48:43], btn_hour_up[49],
    // btn_hour_down[50], btn_min_up[51], btn_min_down[52], btn_mode[53], zero pad
    input  logic [acbc_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // edit_mode[0], alarm_hour_out[5:1], alarm_minute_out[11:6], ringing[12],
    // adjust_minutes[19:13], reset_request[20], tone_freq[31:21], tone_ms[40:32],
    // tone_stop[41], zero pad
    output logic [acbc_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [acbc_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int unsigned PAD_W = acbc_pkg::M_TDATA_W - $bits(acbc_pkg::t_result);

    // configuration
    logic [acbc_pkg::CFG_W-1:0] r_long_press;
    logic [acbc_pkg::CFG_W-1:0] r_edit_timeout;

    // persistent state
    logic                            r_mode_held;
    logic [acbc_pkg::NOW_W-1:0]      r_press_start;
    logic                            r_editing;
    logic [acbc_pkg::NOW_W-1:0]      r_edit_deadline;
    logic [acbc_pkg::HOUR_W-1:0]     r_alarm_hour;
    logic [acbc_pkg::MINUTE_W-1:0]   r_alarm_minute;
    logic                            r_alarm_on;
    logic                            r_last_sec_zero;

    logic                            n_mode_held;
    logic [acbc_pkg::NOW_W-1:0]      n_press_start;
    logic                            n_editing;
    logic [acbc_pkg::NOW_W-1:0]      n_edit_deadline;
    logic [acbc_pkg::HOUR_W-1:0]     n_alarm_hour;
    logic [acbc_pkg::MINUTE_W-1:0]   n_alarm_minute;
    logic                            n_alarm_on;
    logic                            n_last_sec_zero;

    // input register
    logic                            r_in_valid;
    acbc_pkg::t_sample               r_in;
    logic [7:0]                      r_in_rem200;

    // result register
    logic                            r_out_valid;
    acbc_pkg::t_result               r_out;
    acbc_pkg::t_result               n_out;

    acbc_pkg::t_sample               w_sample;
    logic                            w_out_free;
    logic                            w_advance;
    logic                            w_in_take;

    // now_ms mod 200 on the incoming sample
    logic [28:0]                     w_div_x;
    logic [60:0]                     w_div_prod;
    logic [28:0]                     w_div_q;
    logic [28:0]                     w_div_r;
    logic [7:0]                      w_rem200;

    assign w_sample   = acbc_pkg::t_sample'(i_s_tdata[$bits(acbc_pkg::t_sample)-1:0]);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    assign w_div_x    = w_sample.now_ms[acbc_pkg::NOW_W-1:3];
    assign w_div_prod = 61'(w_div_x) * 61'(acbc_pkg::DIV25_MAGIC);
    assign w_div_q    = 29'(w_div_prod >> acbc_pkg::DIV25_SHIFT);
    assign w_div_r    = w_div_x - 29'(w_div_q * 29'd25);
    assign w_rem200   = {w_div_r[4:0], w_sample.now_ms[2:0]};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out};

    // one sample's effect on the state, in the order mode button, dismissal,
    // edit or adjust buttons, edit timeout, alarm trigger, ringing tone
    always_comb begin
        logic [acbc_pkg::NOW_W-1:0]  dur;
        logic [acbc_pkg::NOW_W-1:0]  rearm;
        logic [acbc_pkg::NOW_W-1:0]  past;
        logic                        any_btn;
        logic [acbc_pkg::ADJ_W-1:0]  adj;

        n_mode_held     = r_mode_held;
        n_press_start   = r_press_start;
        n_editing       = r_editing;
        n_edit_deadline = r_edit_deadline;
        n_alarm_hour    = r_alarm_hour;
        n_alarm_minute  = r_alarm_minute;
        n_alarm_on      = r_alarm_on;
        n_out           = '0;
        adj             = '0;

        dur     = r_in.now_ms - r_press_start;
        rearm   = r_in.now_ms + 32'(r_edit_timeout);
        any_btn = r_in.btn_hour_up || r_in.btn_hour_down || r_in.btn_min_up
                  || r_in.btn_min_down || r_in.btn_mode;

        // mode button: press start, or release classified by duration
        if (r_in.btn_mode) begin
            if (!r_mode_held) begin
                n_mode_held   = 1'b1;
                n_press_start = r_in.now_ms;
            end
        end else if (r_mode_held) begin
            n_mode_held = 1'b0;
            if (dur < 32'(r_long_press)) begin
                if (r_editing) begin
                    n_editing       = 1'b0;
                    n_out.tone_freq = acbc_pkg::BEEP_FREQ;
                    n_out.tone_ms   = acbc_pkg::BEEP_MS;
                end else begin
                    n_out.reset_request = 1'b1;
                    n_out.tone_freq     = acbc_pkg::RESET_FREQ;
                    n_out.tone_ms       = acbc_pkg::RESET_MS;
                end
            end else begin
                n_editing       = !r_editing;
                n_edit_deadline = rearm;
                n_out.tone_freq = acbc_pkg::BEEP_FREQ;
                n_out.tone_ms   = acbc_pkg::BEEP_MS;
            end
        end

        // any button dismisses a ringing alarm and cancels earlier tones
        if (any_btn && r_alarm_on) begin
            n_alarm_on      = 1'b0;
            n_out.tone_stop = 1'b1;
            n_out.tone_freq = '0;
            n_out.tone_ms   = '0;
        end

        if (n_editing) begin
            // hour up then hour down, both with wrap
            if (r_in.btn_hour_up) begin
                n_alarm_hour = (n_alarm_hour == acbc_pkg::HOUR_MAX) ? '0 : n_alarm_hour + 5'd1;
            end
            if (r_in.btn_hour_down) begin
                n_alarm_hour = (n_alarm_hour == '0) ? acbc_pkg::HOUR_MAX : n_alarm_hour - 5'd1;
            end
            if (r_in.btn_min_up) begin
                n_alarm_minute = (n_alarm_minute == acbc_pkg::MINUTE_MAX) ? '0
                                 : n_alarm_minute + 6'd1;
            end
            if (r_in.btn_min_down) begin
                n_alarm_minute = (n_alarm_minute == '0) ? acbc_pkg::MINUTE_MAX
                                 : n_alarm_minute - 6'd1;
            end
            if (r_in.btn_hour_up || r_in.btn_hour_down || r_in.btn_min_up
                || r_in.btn_min_down) begin
                n_edit_deadline = rearm;
            end
            // timeout when now is strictly past the deadline (modulo 2^32)
            past = r_in.now_ms - n_edit_deadline;
            if (past != '0 && !past[acbc_pkg::NOW_W-1]) begin
                n_editing       = 1'b0;
                n_out.tone_freq = acbc_pkg::BEEP_FREQ;
                n_out.tone_ms   = acbc_pkg::BEEP_MS;
            end
        end else begin
            past = '0;
            if (r_in.btn_hour_up)   adj = adj + acbc_pkg::ADJ_HOUR;
            if (r_in.btn_hour_down) adj = adj - acbc_pkg::ADJ_HOUR;
            if (r_in.btn_min_up)    adj = adj + acbc_pkg::ADJ_MINUTE;
            if (r_in.btn_min_down)  adj = adj - acbc_pkg::ADJ_MINUTE;
        end

        // trigger outside edit mode on the first sample that shows hour:minute:00
        if (!n_editing && r_in.hour == n_alarm_hour && r_in.minute == n_alarm_minute
            && r_in.second == '0 && !r_last_sec_zero) begin
            n_alarm_on = 1'b1;
        end

        if (n_alarm_on) begin
            n_out.tone_freq = acbc_pkg::RING_BASE + 11'(r_in_rem200);
            n_out.tone_ms   = acbc_pkg::RING_MS;
        end

        n_last_sec_zero = (r_in.second == '0);

        n_out.edit_mode        = n_editing;
        n_out.alarm_hour_out   = n_alarm_hour;
        n_out.alarm_minute_out = n_alarm_minute;
        n_out.ringing          = n_alarm_on;
        n_out.adjust_minutes   = adj;
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press    <= acbc_pkg::LONG_PRESS_RST;
            r_edit_timeout  <= acbc_pkg::EDIT_TIMEOUT_RST;
            r_mode_held     <= 1'b0;
            r_press_start   <= '0;
            r_editing       <= 1'b0;
            r_edit_deadline <= '0;
            r_alarm_hour    <= acbc_pkg::ALARM_HOUR_RST;
            r_alarm_minute  <= '0;
            r_alarm_on      <= 1'b0;
            r_last_sec_zero <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (acbc_pkg::t_cfg_index'(i_cfg_index))
                    acbc_pkg::CFG_LONG_PRESS:   r_long_press   <= i_cfg_wdata;
                    acbc_pkg::CFG_EDIT_TIMEOUT: r_edit_timeout <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_advance) begin
                r_mode_held     <= n_mode_held;
                r_press_start   <= n_press_start;
                r_editing       <= n_editing;
                r_edit_deadline <= n_edit_deadline;
                r_alarm_hour    <= n_alarm_hour;
                r_alarm_minute  <= n_alarm_minute;
                r_alarm_on      <= n_alarm_on;
                r_last_sec_zero <= n_last_sec_zero;
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in        <= w_sample;
            r_in_rem200 <= w_rem200;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/acbc_checker.sv
module acbc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic [acbc_pkg::M_TDATA_W-1:0]       o_m_tdata,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready
);

    logic                              w_edit;
    logic [acbc_pkg::HOUR_W-1:0]       w_hour;
    logic [acbc_pkg::MINUTE_W-1:0]     w_minute;
    logic                              w_ringing;
    logic [acbc_pkg::ADJ_W-1:0]        w_adj;
    logic [acbc_pkg::FREQ_W-1:0]       w_freq;
    logic [acbc_pkg::TMS_W-1:0]        w_tms;

    assign w_edit    = o_m_tdata[0];
    assign w_hour    = o_m_tdata[5:1];
    assign w_minute  = o_m_tdata[11:6];
    assign w_ringing = o_m_tdata[12];
    assign w_adj     = o_m_tdata[19:13];
    assign w_freq    = o_m_tdata[31:21];
    assign w_tms     = o_m_tdata[40:32];

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a tone has a duration exactly when it has a frequency
    a_tone_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((w_freq == '0) == (w_tms == '0)))
        else $error("tone frequency and duration disagree");

    // editing never adjusts the clock; an alarm already ringing may carry into edit
    a_edit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_edit |-> w_adj == '0)
        else $error("edit mode with adjustment");

    // ringing tone and stored alarm time stay in range
    a_ring_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!w_ringing || w_tms == acbc_pkg::RING_MS)
                       && w_hour <= acbc_pkg::HOUR_MAX && w_minute <= acbc_pkg::MINUTE_MAX)
        else $error("ringing tone or alarm time out of range");

endmodule

bind alarm_clock_button_controller acbc_checker u_acbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import acbc_pkg::*;

    // button masks, bit order as in the sample struct
    localparam logic [4:0] NO_KEYS        = 5'b00000;
    localparam logic [4:0] KEY_HOUR_UP    = 5'b00001;
    localparam logic [4:0] KEY_HOUR_DOWN  = 5'b00010;
    localparam logic [4:0] KEY_MIN_UP     = 5'b00100;
    localparam logic [4:0] KEY_MIN_DOWN   = 5'b01000;
    localparam logic [4:0] KEY_MODE       = 5'b10000;
    localparam logic [4:0] KEY_ALL_ADJUST = 5'b01111;

    // tones as the controller should request them
    localparam logic [FREQ_W-1:0] TONE_BEEP_HZ  = 11'd500;
    localparam logic [TMS_W-1:0]  TONE_BEEP_MS  = 9'd100;
    localparam logic [FREQ_W-1:0] TONE_RESET_HZ = 11'd800;
    localparam logic [TMS_W-1:0]  TONE_RESET_MS = 9'd200;
    localparam logic [FREQ_W-1:0] TONE_RING_HZ  = 11'd1000;
    localparam logic [TMS_W-1:0]  TONE_RING_MS  = 9'd500;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 240;
    localparam int SHOWN_ERRORS   = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    // now_ms, hour, minute, second, btn_hour_up, btn_hour_down, btn_min_up,
    // btn_min_down, btn_mode, zero pad
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // edit_mode, alarm_hour_out, alarm_minute_out, ringing, adjust_minutes,
    // reset_request, tone_freq, tone_ms, tone_stop, zero pad
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    alarm_clock_button_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // controller state as the bench tracks it
    logic [CFG_W-1:0]    long_press_lim;
    logic [CFG_W-1:0]    edit_idle_lim;
    logic                mode_down;
    logic [31:0]         press_t0;
    logic                in_edit;
    logic [31:0]         edit_expiry;
    logic [HOUR_W-1:0]   alm_hour;
    logic [MINUTE_W-1:0] alm_min;
    logic                alm_active;
    logic                sec_was_zero;

    t_sample sample_backlog[$];
    t_result expected_responses[$];

    // stimulus generator position
    logic [31:0]         gen_now;
    logic [HOUR_W-1:0]   gen_hr;
    logic [MINUTE_W-1:0] gen_min;
    logic [SECOND_W-1:0] gen_sec;
    int                  items_queued;

    // handshake bookkeeping
    logic sample_fire = 1'b0;
    logic result_fire = 1'b0;
    int   send_gap, recv_gap;
    int   send_idle_odds, recv_idle_odds;
    bit   quiet_tail;
    int   quiet_cycles;
    int   results_seen;
    int   bad_results;

    // one sample through the controller: mode button, dismissal, edit or adjust,
    // edit timeout, alarm trigger, ringing tone
    function automatic t_result controller_response(input t_sample smp);
        t_result                 r;
        logic [31:0]             held_ms;
        logic [31:0]             overdue;
        logic signed [ADJ_W-1:0] net;
        logic                    adj_key;
        r = '0;
        net = '0;
        adj_key = smp.btn_hour_up | smp.btn_hour_down | smp.btn_min_up | smp.btn_min_down;
        if (smp.btn_mode) begin
            if (!mode_down) begin
                mode_down = 1'b1;
                press_t0 = smp.now_ms;
            end
        end else if (mode_down) begin
            held_ms = smp.now_ms - press_t0;
            mode_down = 1'b0;
            if (held_ms < 32'(long_press_lim)) begin
                if (in_edit) begin
                    in_edit = 1'b0;
                    r.tone_freq = TONE_BEEP_HZ;
                    r.tone_ms = TONE_BEEP_MS;
                end else begin
                    r.reset_request = 1'b1;
                    r.tone_freq = TONE_RESET_HZ;
                    r.tone_ms = TONE_RESET_MS;
                end
            end else begin
                in_edit = !in_edit;
                edit_expiry = smp.now_ms + 32'(edit_idle_lim);
                r.tone_freq = TONE_BEEP_HZ;
                r.tone_ms = TONE_BEEP_MS;
            end
        end
        // any button silences the alarm and drops a tone started so far
        if ((adj_key || smp.btn_mode) && alm_active) begin
            alm_active = 1'b0;
            r.tone_stop = 1'b1;
            r.tone_freq = '0;
            r.tone_ms = '0;
        end
        if (in_edit) begin
            if (smp.btn_hour_up)
                alm_hour = (alm_hour == 23) ? '0 : HOUR_W'(alm_hour + 1);
            if (smp.btn_hour_down)
                alm_hour = (alm_hour == 0) ? HOUR_W'(23) : HOUR_W'(alm_hour - 1);
            if (smp.btn_min_up)
                alm_min = (alm_min == 59) ? '0 : MINUTE_W'(alm_min + 1);
            if (smp.btn_min_down)
                alm_min = (alm_min == 0) ? MINUTE_W'(59) : MINUTE_W'(alm_min - 1);
            if (adj_key)
                edit_expiry = smp.now_ms + 32'(edit_idle_lim);
            // past the deadline means a nonzero distance in the lower half of the ring
            overdue = smp.now_ms - edit_expiry;
            if (overdue != 0 && !overdue[31]) begin
                in_edit = 1'b0;
                r.tone_freq = TONE_BEEP_HZ;
                r.tone_ms = TONE_BEEP_MS;
            end
        end else begin
            if (smp.btn_hour_up)   net = net + 7'sd60;
            if (smp.btn_hour_down) net = net - 7'sd60;
            if (smp.btn_min_up)    net = net + 7'sd1;
            if (smp.btn_min_down)  net = net - 7'sd1;
        end
        if (!in_edit && smp.hour == alm_hour && smp.minute == alm_min &&
            smp.second == 0 && !sec_was_zero)
            alm_active = 1'b1;
        if (alm_active) begin
            r.tone_freq = TONE_RING_HZ + FREQ_W'(smp.now_ms % 200);
            r.tone_ms = TONE_RING_MS;
        end
        sec_was_zero = (smp.second == 0);
        r.edit_mode = in_edit;
        r.alarm_hour_out = alm_hour;
        r.alarm_minute_out = alm_min;
        r.ringing = alm_active;
        r.adjust_minutes = net;
        return r;
    endfunction

    function automatic string fmt_response(input t_result r);
        return $sformatf("edit=%0b alarm=%0d:%0d ring=%0b adj=%0d rst=%0b tone=%0d/%0d stop=%0b",
                         r.edit_mode, r.alarm_hour_out, r.alarm_minute_out, r.ringing,
                         $signed(r.adjust_minutes), r.reset_request, r.tone_freq,
                         r.tone_ms, r.tone_stop);
    endfunction

    function automatic void check_response(input t_result want, input t_result got,
                                           input logic [M_TDATA_W-$bits(t_result)-1:0] pad);
        string bad;
        bad = "";
        if (got.edit_mode !== want.edit_mode)               bad = {bad, " edit_mode"};
        if (got.alarm_hour_out !== want.alarm_hour_out)     bad = {bad, " alarm_hour_out"};
        if (got.alarm_minute_out !== want.alarm_minute_out) bad = {bad, " alarm_minute_out"};
        if (got.ringing !== want.ringing)                   bad = {bad, " ringing"};
        if (got.adjust_minutes !== want.adjust_minutes)     bad = {bad, " adjust_minutes"};
        if (got.reset_request !== want.reset_request)       bad = {bad, " reset_request"};
        if (got.tone_freq !== want.tone_freq)               bad = {bad, " tone_freq"};
        if (got.tone_ms !== want.tone_ms)                   bad = {bad, " tone_ms"};
        if (got.tone_stop !== want.tone_stop)               bad = {bad, " tone_stop"};
        if (pad !== '0)                                     bad = {bad, " padding"};
        if (bad != "") begin
            bad_results++;
            if (bad_results <= SHOWN_ERRORS)
                $display("result %0d wrong in%s: expected %s, got %s", results_seen, bad,
                         fmt_response(want), fmt_response(got));
        end
    endfunction

    // sample and check at the rising edge
    always @(posedge i_clk) begin
        t_result got;
        sample_fire = i_rst_n && i_s_tvalid && o_s_tready;
        result_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (result_fire) begin
            got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            if (expected_responses.size() == 0) begin
                bad_results++;
                if (bad_results <= SHOWN_ERRORS)
                    $display("result %0d arrived with nothing expected: %s", results_seen,
                             fmt_response(got));
            end else begin
                check_response(expected_responses.pop_front(), got,
                               o_m_tdata[M_TDATA_W-1:$bits(t_result)]);
            end
            results_seen++;
        end
        if (sample_fire)
            expected_responses.push_back(
                controller_response(t_sample'(i_s_tdata[$bits(t_sample)-1:0])));
        // watchdog: no transaction on either side for too long
        if (sample_fire || result_fire) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // drive both sides at the falling edge
    always @(negedge i_clk) begin
        t_sample next_smp;
        if (i_rst_n) begin
            if (!i_s_tvalid || sample_fire) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    next_smp = sample_backlog.pop_front();
                    i_s_tdata <= S_TDATA_W'(next_smp);
                    i_s_tvalid <= 1'b1;
                    if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1)
                    recv_gap = $urandom_range(1, 13);
            end
        end
    end

    task automatic add_raw(input logic [31:0] now, input logic [HOUR_W-1:0] hr,
                           input logic [MINUTE_W-1:0] mn, input logic [SECOND_W-1:0] sc,
                           input logic [4:0] keys);
        t_sample smp;
        smp.now_ms = now;
        smp.hour = hr;
        smp.minute = mn;
        smp.second = sc;
        smp.btn_hour_up = |(keys & KEY_HOUR_UP);
        smp.btn_hour_down = |(keys & KEY_HOUR_DOWN);
        smp.btn_min_up = |(keys & KEY_MIN_UP);
        smp.btn_min_down = |(keys & KEY_MIN_DOWN);
        smp.btn_mode = |(keys & KEY_MODE);
        sample_backlog.push_back(smp);
        items_queued++;
    endtask

    // next sample on the running timeline, seconds tick without carry
    task automatic add_sample(input logic [4:0] keys, input logic [31:0] step_ms);
        gen_now = gen_now + step_ms;
        add_raw(gen_now, gen_hr, gen_min, gen_sec, keys);
        gen_sec = (gen_sec == 59) ? '0 : SECOND_W'(gen_sec + 1);
    endtask

    // every queued sample accepted, so the tracked state is current
    task automatic drain_backlog();
        do @(posedge i_clk); while (sample_backlog.size() != 0 || i_s_tvalid);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_backlog.size() != 0 || i_s_tvalid || expected_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_LONG_PRESS)
            long_press_lim = val;
        else
            edit_idle_lim = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // press and release of the mode button, held items in between
    task automatic mode_press(input bit go_long);
        logic [31:0] hold;
        int          n;
        if (go_long || long_press_lim == 0)
            hold = 32'(long_press_lim) + ($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 2000)));
        else if ($urandom_range(0, 3) == 0)
            hold = 32'(long_press_lim) - 1;
        else
            hold = $urandom_range(0, long_press_lim - 1);
        add_sample(KEY_MODE, $urandom_range(0, 300));
        n = $urandom_range(0, 2);
        repeat (n)
            add_sample(KEY_MODE | ($urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 15)) : NO_KEYS), 0);
        add_sample($urandom_range(0, 1) ? NO_KEYS : 5'($urandom_range(0, 15)), hold);
    endtask

    task automatic edit_session();
        int          n;
        logic [4:0]  keys;
        mode_press(1);
        if ($urandom_range(0, 3) == 0) begin
            // one button over and over, enough to wrap hour or minute
            keys = 5'(1 << $urandom_range(0, 3));
            n = ((keys & (KEY_MIN_UP | KEY_MIN_DOWN)) != 0) ? 61 : 25;
            repeat (n) add_sample(keys, $urandom_range(0, 50));
        end else begin
            n = $urandom_range(2, 14);
            repeat (n) begin
                keys = ($urandom_range(0, 3) == 0) ? NO_KEYS : 5'($urandom_range(1, 15));
                add_sample(keys, $urandom_range(0, edit_idle_lim));
            end
        end
        case ($urandom_range(0, 3))
            0: mode_press(0);
            1: add_sample(NO_KEYS, 32'(edit_idle_lim) + 32'($urandom_range(0, 1)));
            2: mode_press(1);
            default: ;
        endcase
    endtask

    // walk the clock onto the alarm time and let it ring; a button then dismisses it or lands on the trigger second
    task automatic alarm_cycle();
        int n;
        drain_backlog();
        while (mode_down || in_edit) begin
            add_sample(KEY_MODE, 0);
            add_sample(NO_KEYS, 0);
            drain_backlog();
        end
        gen_hr = alm_hour;
        gen_min = alm_min;
        gen_sec = SECOND_W'(60 - $urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) begin
            // button pressed right at the trigger second
            while (gen_sec != 0) add_sample(NO_KEYS, $urandom_range(1, 700));
            add_sample(5'($urandom_range(1, 31)), $urandom_range(1, 700));
        end else begin
            n = $urandom_range(3, 8);
            repeat (n) add_sample(NO_KEYS, $urandom_range(1, 700));
            add_sample(5'($urandom_range(1, 31)), $urandom_range(1, 700));
        end
    endtask

    task automatic run_scenario();
        int n;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            send_idle_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 10);
            recv_idle_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 10);
        end
        case ($urandom_range(0, 9))
            0: begin
                // unstructured samples over the full field ranges
                n = $urandom_range(1, 4);
                repeat (n) begin
                    gen_now = $urandom;
                    add_raw(gen_now, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
                end
            end
            1, 2: mode_press(0);
            3, 4: edit_session();
            5: begin
                n = $urandom_range(1, 5);
                repeat (n) add_sample(5'($urandom_range(0, 15)), $urandom_range(0, 400));
            end
            6, 7: alarm_cycle();
            8: begin
                n = $urandom_range(1, 6);
                repeat (n) add_sample(NO_KEYS, $urandom_range(0, 2000));
            end
            default: begin
                // timestamp jump, often to just before the wrap, and a new clock time
                gen_now = $urandom_range(0, 1) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3000))
                                               : gen_now + $urandom;
                gen_hr = 5'($urandom_range(0, 23));
                gen_min = 6'($urandom_range(0, 59));
                add_sample(NO_KEYS, 0);
            end
        endcase
    endtask

    initial begin
        int phase_start;
        i_rst_n = 1'b0;
        i_s_tdata = '0;
        i_s_tvalid = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LONG_PRESS;
        i_cfg_wdata = '0;
        long_press_lim = 16'd1000;
        edit_idle_lim = 16'd5000;
        mode_down = 1'b0;
        press_t0 = '0;
        in_edit = 1'b0;
        edit_expiry = '0;
        alm_hour = 5'd12;
        alm_min = '0;
        alm_active = 1'b0;
        sec_was_zero = 1'b0;
        send_idle_odds = 4;
        recv_idle_odds = 4;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // alarm at reset time rings at once since the previous second is unknown
        add_raw(32'd0, 5'd12, 6'd0, 6'd0, NO_KEYS);
        add_raw(32'd199, 5'd12, 6'd0, 6'd0, NO_KEYS);
        add_raw(32'd200, 5'd12, 6'd0, 6'd1, KEY_HOUR_UP);
        add_raw(32'd300, 5'd0, 6'd0, 6'd2, KEY_HOUR_DOWN | KEY_MIN_DOWN);
        add_raw(32'd400, 5'd23, 6'd59, 6'd59, KEY_HOUR_UP | KEY_MIN_UP);
        // short press across the timestamp wrap: reset request plus adjustment
        add_raw(32'hFFFF_FF00, 5'd31, 6'd63, 6'd63, KEY_MODE);
        add_raw(32'h0000_0100, 5'd31, 6'd63, 6'd0, KEY_MIN_UP);
        // press held exactly the long limit enters edit
        add_raw(32'h8000_0000, 5'd12, 6'd0, 6'd5, KEY_MODE);
        add_raw(32'h8000_03E8, 5'd12, 6'd0, 6'd6, NO_KEYS);
        add_raw(32'h8000_03F2, 5'd12, 6'd0, 6'd7, KEY_HOUR_DOWN);
        add_raw(32'h8000_03FC, 5'd12, 6'd0, 6'd8, KEY_MIN_DOWN);
        add_raw(32'h8000_0406, 5'd12, 6'd0, 6'd9, KEY_ALL_ADJUST);
        // deadline reached stays in edit, one ms later leaves it
        add_raw(32'h8000_178E, 5'd12, 6'd0, 6'd10, NO_KEYS);
        add_raw(32'h8000_178F, 5'd12, 6'd0, 6'd11, NO_KEYS);
        // back into edit, then a short press leaves it with an adjustment
        add_raw(32'h8000_1B58, 5'd12, 6'd0, 6'd12, KEY_MODE);
        add_raw(32'h8000_2134, 5'd12, 6'd0, 6'd13, NO_KEYS);
        add_raw(32'h8000_2198, 5'd12, 6'd0, 6'd14, KEY_MODE);
        add_raw(32'h8000_21FC, 5'd12, 6'd0, 6'd15, KEY_HOUR_UP);
        // alarm now 11:59, triggers while mode is held
        add_raw(32'h8000_2328, 5'd11, 6'd59, 6'd59, KEY_MODE);
        add_raw(32'h8000_2329, 5'd11, 6'd59, 6'd0, KEY_MODE);
        // release tone dropped by the dismissal in the same step
        add_raw(32'h8000_238C, 5'd11, 6'd59, 6'd1, KEY_MIN_UP);
        add_raw(32'h8000_23F0, 5'd11, 6'd59, 6'd0, NO_KEYS);
        add_raw(32'h8000_2454, 5'd11, 6'd59, 6'd1, NO_KEYS);
        // dismissed and retriggered in one step
        add_raw(32'h8000_24B8, 5'd11, 6'd59, 6'd0, KEY_MIN_DOWN);
        // second zero twice in a row does not retrigger
        add_raw(32'h8000_251C, 5'd11, 6'd59, 6'd0, KEY_HOUR_DOWN);

        gen_now = 32'h8000_2600;
        gen_hr = 5'd7;
        gen_min = 6'd30;
        gen_sec = '0;

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        write_reg(CFG_LONG_PRESS, 16'd200);
                        write_reg(CFG_EDIT_TIMEOUT, 16'd1500);
                    end
                    2: begin
                        write_reg(CFG_LONG_PRESS, 16'd0);
                        write_reg(CFG_EDIT_TIMEOUT, 16'd0);
                    end
                    3: begin
                        write_reg(CFG_LONG_PRESS, 16'hFFFF);
                        write_reg(CFG_EDIT_TIMEOUT, 16'hFFFF);
                    end
                    default: begin
                        write_reg(CFG_LONG_PRESS, 16'($urandom_range(1, 3000)));
                        write_reg(CFG_EDIT_TIMEOUT, 16'($urandom_range(0, 20000)));
                    end
                endcase
            end
            // last phase runs with both sides always ready
            if (ph == 4) begin
                quiet_tail = 1'b1;
                send_idle_odds = 0;
                recv_idle_odds = 0;
            end
            phase_start = (ph == 0) ? 0 : items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) run_scenario();
        end

        wait_idle();
        if (bad_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
